// ===== hw/rtl/mptu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mptu_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned METRIC_W = 32;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned HOP_W    = 9;

  typedef struct packed {
    logic [ADDR_W-1:0]   dest;
    logic [ADDR_W-1:0]   fwd_mac;
    logic                seqno_known;
    logic [SEQ_W-1:0]    seqno;
    logic [TIME_W-1:0]   expiry;
    logic [METRIC_W-1:0] metric;
    logic [HOP_W-1:0]    hops;
  } entry_t;

  // serial-number order: a precedes b when b - a lies in the lower half circle
  function automatic logic seq_precedes(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = b - a;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mesh_path_table_update_top.sv =====
// Flow: an accepted start scans the held entries for the remote address, then decides and
// writes; unless transmitter and remote address are equal, a second scan and decision
// follow for the transmitter entry. One transaction at a time: busy falls as done rises.
// Each key search reads the entry memory once per cycle through its single read port.
// The receiver cannot stall; done is valid for one cycle, the result ports until the next done.
// Reset empties the table by clearing the fill count; entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mesh_path_table_update_top
  import mptu_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ADDR_W-1:0]   tx_mac,
  input  wire logic [ADDR_W-1:0]   peer_mac,
  input  wire logic [SEQ_W-1:0]    remote_seqno,
  input  wire logic [METRIC_W-1:0] adv_metric,
  input  wire logic [METRIC_W-1:0] link_metric,
  input  wire logic [7:0]          hops,
  input  wire logic [31:0]         path_life_tu,
  input  wire logic [TIME_W-1:0]   now_tu,
  output logic                     done,
  output logic                     remote_updated,
  output logic                     sender_updated,
  output logic [METRIC_W-1:0]      remote_total_metric,
  output logic [HOP_W-1:0]         remote_hop_count,
  output logic                     table_full
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  // control
  logic [1:0]       state;
  logic             phase;      // 0: remote entry, 1: transmitter entry
  logic [CNT_W-1:0] cnt;        // entries are never removed: slots 0..cnt-1 are live
  logic [CNT_W-1:0] scan_idx;
  logic             pend;
  logic             hit;
  logic             rem_upd;
  logic             full;

  // payload
  logic [IDX_W-1:0]    pend_idx;
  logic [IDX_W-1:0]    hit_slot;
  entry_t              hit_e;
  logic [ADDR_W-1:0]   tx_addr;
  logic [ADDR_W-1:0]   rem_addr;
  logic [SEQ_W-1:0]    seq;
  logic [METRIC_W-1:0] total;
  logic [METRIC_W-1:0] link;
  logic [HOP_W-1:0]    hop_cnt;
  logic [TIME_W-1:0]   fresh;

  entry_t           mem [TABLE_ENTRIES];
  entry_t           rdata;
  logic [IDX_W-1:0] rd_addr;

  logic [ADDR_W-1:0] key;
  logic              match;
  logic              need_rem;
  logic              need_tx;
  logic              want;
  logic              have_slot;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [TIME_W-1:0] old_exp;
  entry_t            wr_data;
  logic              accept;
  logic              last;
  logic              rem_fin;
  logic              snd_fin;
  logic              full_fin;
  logic [TIME_W:0]   exp_sum;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign exp_sum = {1'b0, now_tu} + (TIME_W + 1)'(path_life_tu);

  assign rd_addr = scan_idx[IDX_W-1:0];
  assign key     = phase ? tx_addr : rem_addr;
  assign match   = pend && (rdata.dest == key);

  always_comb begin
    need_rem = !hit
            || (hit_e.seqno_known && seq_precedes(hit_e.seqno, seq))
            || ((!hit_e.seqno_known || hit_e.seqno == seq) && (hit_e.metric > total));
    need_tx   = !hit || (hit_e.metric > total);
    want      = phase ? need_tx : need_rem;
    have_slot = hit || (cnt < CNT_W'(TABLE_ENTRIES));
    wr_en     = (state == ST_DECIDE) && want && have_slot;
    wr_idx    = hit ? hit_slot : cnt[IDX_W-1:0];
    old_exp   = hit ? hit_e.expiry : '0;

    wr_data.dest     = key;
    wr_data.fwd_mac  = tx_addr;
    wr_data.expiry   = (old_exp > fresh) ? old_exp : fresh;
    if (phase) begin
      wr_data.seqno_known = hit && hit_e.seqno_known;
      wr_data.seqno       = hit ? hit_e.seqno : '0;
      wr_data.metric      = link;
      wr_data.hops        = HOP_W'(1);
    end else begin
      wr_data.seqno_known = 1'b1;
      wr_data.seqno       = seq;
      wr_data.metric      = total;
      wr_data.hops        = hop_cnt;
    end

    last     = phase || (tx_addr == rem_addr);
    rem_fin  = phase ? rem_upd : wr_en;
    snd_fin  = phase && wr_en;
    full_fin = full || (want && !have_slot);
  end

  // entry memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= 1'b0;
      cnt      <= '0;
      scan_idx <= '0;
      pend     <= 1'b0;
      hit      <= 1'b0;
      rem_upd  <= 1'b0;
      full     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase    <= 1'b0;
            scan_idx <= '0;
            pend     <= 1'b0;
            rem_upd  <= 1'b0;
            full     <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match) begin
            hit   <= 1'b1;
            pend  <= 1'b0;
            state <= ST_DECIDE;
          end else if (scan_idx == cnt) begin
            hit   <= 1'b0;
            pend  <= 1'b0;
            state <= ST_DECIDE;
          end else begin
            pend     <= 1'b1;
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end
        ST_DECIDE: begin
          if (wr_en && !hit) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (want && !have_slot) begin
            full <= 1'b1;
          end
          if (!phase) begin
            rem_upd <= wr_en;
          end
          if (last) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            phase    <= 1'b1;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_addr  <= tx_mac;
      rem_addr <= peer_mac;
      seq      <= remote_seqno;
      total    <= adv_metric + link_metric;
      link     <= link_metric;
      hop_cnt  <= {1'b0, hops} + HOP_W'(1);
      fresh    <= exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
    end
    if (state == ST_SCAN && !match && scan_idx != cnt) begin
      pend_idx <= scan_idx[IDX_W-1:0];
    end
    if (state == ST_SCAN && match) begin
      hit_slot <= pend_idx;
      hit_e    <= rdata;
    end
    if (state == ST_DECIDE && last) begin
      remote_updated      <= rem_fin;
      sender_updated      <= snd_fin;
      remote_total_metric <= rem_fin ? total : '0;
      remote_hop_count    <= rem_fin ? hop_cnt : '0;
      table_full          <= full_fin;
    end
  end

  a_done_from_decide: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_DECIDE)
    else $error("result strobe without a decision cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cnt != $past(cnt)) |-> (cnt == $past(cnt) + CNT_W'(1)
      && $past(state) == ST_DECIDE))
    else $error("fill count moved other than by one insert");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

endmodule
`default_nettype wire
